/* hw/rtl/fifo_queue_with_search_assert.svh */
// ----------------------------------------------------------------------------
// fifo_queue_with_search assertion macros
// Clocked assertion shorthands used by the checker file of the queue.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fqs_pkg.sv */
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types, codes and constants of the searchable queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W       = 32;
	localparam int OCC_W         = 5;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_COUNT  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_code_t;

	typedef struct packed {
		req_type_t                  req_type;
		logic signed [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_code_t               status;
		logic signed [VALUE_W-1:0]  removed_value;
		logic                       found;
		logic [OCC_W-1:0]           occupancy;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REMOVE,
		ST_SCAN
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         capture;
		logic         write_tail;
		logic         pop_head;
		logic         rd_head;
		logic         scan_step;
		logic         load_out;
		status_code_t status;
		logic         found;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_type_t req_type;
		logic      full;
		logic      empty;
		logic      match;
		logic      last;
		logic      out_free;
	} dp_status_t;

endpackage

/* hw/rtl/fifo_queue_with_search.sv */
// Insert and count load their result in the execution state; remove reads the head first.
// A search reads the head and then compares the held entries in turn until a result loads.
// Throughput: one request at a time; the next is taken the cycle after a result loads.
// The search rate is one entry per cycle, set by the single read port of the ring store.
// Reset (arst_n low) empties the queue at once; store contents are left as they are.
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// First-in first-out queue of signed 32-bit values in a ring store, with
// insert, remove, linear search and count requests.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fqs_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output fqs_pkg::out_item_t rsp
);

	// The controller steps each item through capture, execution and, for a
	// remove or a search, the reads of the ring store. The datapath holds the
	// pointers, the entry count and a result register, so a finished result
	// can wait for the consumer while the next item is already being taken.
	fqs_pkg::cmd_t       cmd;
	fqs_pkg::dp_status_t sts;

	fqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A search reads the head entry first and then walks toward the tail one
	// entry per cycle, stopping at the first entry equal on all 32 bits or
	// after the last held entry.
	fqs_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* hw/rtl/fqs_ctrl.sv */
// ----------------------------------------------------------------------------
// fqs_ctrl
// Sequencer that steps one request at a time through the queue datapath.
// ----------------------------------------------------------------------------
module fqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output fqs_pkg::cmd_t      cmd,
	input  fqs_pkg::dp_status_t sts
);

	fqs_pkg::ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			fqs_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = fqs_pkg::ST_EXEC;
				end
			end
			fqs_pkg::ST_EXEC: begin
				case (sts.req_type)
					fqs_pkg::REQ_REMOVE: begin
						if (!sts.empty) begin
							state_next = fqs_pkg::ST_REMOVE;
						end else if (sts.out_free) begin
							state_next = fqs_pkg::ST_IDLE;
						end
					end
					fqs_pkg::REQ_SEARCH: begin
						if (!sts.empty) begin
							state_next = fqs_pkg::ST_SCAN;
						end else if (sts.out_free) begin
							state_next = fqs_pkg::ST_IDLE;
						end
					end
					default: begin
						if (sts.out_free) begin
							state_next = fqs_pkg::ST_IDLE;
						end
					end
				endcase
			end
			fqs_pkg::ST_REMOVE: begin
				if (sts.out_free) begin
					state_next = fqs_pkg::ST_IDLE;
				end
			end
			fqs_pkg::ST_SCAN: begin
				if ((sts.match || sts.last) && sts.out_free) begin
					state_next = fqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = fqs_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd        = '0;
		cmd.status = fqs_pkg::STAT_OK;
		req_stall  = 1'b1;
		case (state_q)
			fqs_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			fqs_pkg::ST_EXEC: begin
				case (sts.req_type)
					fqs_pkg::REQ_INSERT: begin
						if (sts.out_free) begin
							cmd.load_out = 1'b1;
							if (sts.full) begin
								cmd.status = fqs_pkg::STAT_FULL;
							end else begin
								cmd.write_tail = 1'b1;
							end
						end
					end
					fqs_pkg::REQ_REMOVE, fqs_pkg::REQ_SEARCH: begin
						if (!sts.empty) begin
							cmd.rd_head = 1'b1;
						end else if (sts.out_free) begin
							cmd.load_out = 1'b1;
							cmd.status   = fqs_pkg::STAT_EMPTY;
						end
					end
					default: begin
						cmd.load_out = sts.out_free;
					end
				endcase
			end
			fqs_pkg::ST_REMOVE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.pop_head = 1'b1;
				end
			end
			fqs_pkg::ST_SCAN: begin
				if (sts.match) begin
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						cmd.found    = 1'b1;
					end
				end else if (sts.last) begin
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						cmd.status   = fqs_pkg::STAT_NOTFOUND;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

/* hw/rtl/fqs_datapath.sv */
// ----------------------------------------------------------------------------
// fqs_datapath
// Ring store, head and tail pointers, entry count, scan pointer and the
// result register of the queue.
// ----------------------------------------------------------------------------
module fqs_datapath #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fqs_pkg::in_item_t   req,
	input  fqs_pkg::cmd_t       cmd,
	output fqs_pkg::dp_status_t sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output fqs_pkg::out_item_t  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [fqs_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [fqs_pkg::VALUE_W-1:0] rdata_q;
	logic signed [fqs_pkg::VALUE_W-1:0] value_q;
	fqs_pkg::req_type_t                 req_type_q;
	logic [AW-1:0]                      head_q, tail_q, scan_q, rd_addr;
	logic [CW-1:0]                      count_q, left_q, count_next;
	logic                               rd_en;
	logic                               rsp_valid_q;
	fqs_pkg::out_item_t                 rsp_q;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign rd_en   = cmd.rd_head | cmd.scan_step;
	assign rd_addr = cmd.rd_head ? head_q : scan_q;

	always_comb begin
		count_next = count_q;
		if (cmd.write_tail) begin
			count_next = count_q + 1'b1;
		end else if (cmd.pop_head) begin
			count_next = count_q - 1'b1;
		end
	end

	// Ring store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write_tail) begin
			mem[tail_q] <= value_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req.req_type;
			value_q    <= req.value;
		end
		if (cmd.rd_head) begin
			scan_q <= next_idx(head_q);
			left_q <= count_q;
		end else if (cmd.scan_step) begin
			scan_q <= next_idx(scan_q);
			left_q <= left_q - 1'b1;
		end
		if (cmd.load_out) begin
			rsp_q.status        <= cmd.status;
			rsp_q.removed_value <= cmd.pop_head ? rdata_q : '0;
			rsp_q.found         <= cmd.found;
			rsp_q.occupancy     <= fqs_pkg::OCC_W'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.write_tail) begin
				tail_q <= next_idx(tail_q);
			end
			if (cmd.pop_head) begin
				head_q <= next_idx(head_q);
			end
			count_q <= count_next;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.req_type = req_type_q;
	assign sts.full     = (count_q == CW'(DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.match    = (rdata_q == value_q);
	assign sts.last     = (left_q == CW'(1));
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/fqs_checker.sv */
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks of the searchable queue, bound to its top level.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_search_assert.svh"

module fqs_checker #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input fqs_pkg::out_item_t rsp
);

	// A stalled result stays offered.
	`FQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

	// A stalled result does not change.
	`FQS_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp), "stalled result changed")

	// Items are taken one at a time.
	`FQS_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "item taken while busy")

	// A rejected insert sees a full queue.
	`FQS_ASSERT_NOW(a_full_occ, rsp_valid && (rsp.status == fqs_pkg::STAT_FULL), rsp.occupancy == fqs_pkg::OCC_W'(DEPTH), "full reported below capacity")

	// A found flag only comes with a good status.
	`FQS_ASSERT_NOW(a_found_ok, rsp_valid && rsp.found, rsp.status == fqs_pkg::STAT_OK, "found with bad status")

endmodule

bind fifo_queue_with_search fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (.*);

/* bench/tb_fifo_queue_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_search
// Self-checking bench for the searchable ring queue. A directed opening run
// hits the empty, full, first-match, last-match and near-miss cases. Random
// request streams follow that steer the fill level between empty and full,
// under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------

// Tracks the queue contents as the block should hold them and keeps the
// responses that accepted requests must produce, oldest first.
class queue_tracker;
	localparam int unsigned SLOTS = fqs_pkg::DEPTH_DEFAULT;

	logic signed [fqs_pkg::VALUE_W-1:0] ring [SLOTS];
	int unsigned head_at = 0;
	int unsigned tail_at = 0;
	int unsigned held = 0;
	fqs_pkg::out_item_t pending_rsp [$];

	int unsigned mismatches = 0;
	int unsigned n_requests = 0;
	int unsigned n_checked = 0;
	int unsigned n_full = 0;
	int unsigned n_empty = 0;
	int unsigned n_found = 0;
	int unsigned n_miss = 0;
	int unsigned peak = 0;

	// Value held k entries behind the head; only called with k < held.
	function logic signed [fqs_pkg::VALUE_W-1:0] held_value(int unsigned k);
		return ring[(head_at + k) % SLOTS];
	endfunction

	function void note_request(fqs_pkg::in_item_t item);
		fqs_pkg::out_item_t want;
		want = '0;
		n_requests++;
		case (item.req_type)
			fqs_pkg::REQ_INSERT: begin
				if (held >= SLOTS) begin
					want.status = fqs_pkg::STAT_FULL;
					n_full++;
				end else begin
					ring[tail_at] = item.value;
					tail_at = (tail_at + 1) % SLOTS;
					held++;
				end
			end
			fqs_pkg::REQ_REMOVE: begin
				if (held == 0) begin
					want.status = fqs_pkg::STAT_EMPTY;
					n_empty++;
				end else begin
					want.removed_value = ring[head_at];
					head_at = (head_at + 1) % SLOTS;
					held--;
				end
			end
			fqs_pkg::REQ_SEARCH: begin
				if (held == 0) begin
					want.status = fqs_pkg::STAT_EMPTY;
					n_empty++;
				end else begin
					for (int unsigned k = 0; k < held; k++)
						if (ring[(head_at + k) % SLOTS] == item.value)
							want.found = 1'b1;
					if (want.found) begin
						want.status = fqs_pkg::STAT_OK;
						n_found++;
					end else begin
						want.status = fqs_pkg::STAT_NOTFOUND;
						n_miss++;
					end
				end
			end
			default: begin
			end
		endcase
		if (held > peak)
			peak = held;
		want.occupancy = fqs_pkg::OCC_W'(held);
		pending_rsp.push_back(want);
	endfunction

	function void check_response(fqs_pkg::out_item_t got);
		fqs_pkg::out_item_t want;
		if (pending_rsp.size() == 0) begin
			$error("response item arrived with no request outstanding");
			mismatches++;
			return;
		end
		want = pending_rsp.pop_front();
		n_checked++;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
		if (got.removed_value !== want.removed_value) begin
			$error("removed_value: expected %0d, got %0d",
				want.removed_value, got.removed_value);
			mismatches++;
		end
		if (got.found !== want.found) begin
			$error("found: expected %0d, got %0d", want.found, got.found);
			mismatches++;
		end
		if (got.occupancy !== want.occupancy) begin
			$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
			mismatches++;
		end
	endfunction
endclass

module tb_fifo_queue_with_search;
	import fqs_pkg::*;

	localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
	// A search compares at most DEPTH entries; each random gap or stall is
	// short on average, so this leaves a wide margin over the slowest run.
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned ITEMS_PER_PHASE = 400;
	localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
	localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;
	localparam logic signed [VALUE_W-1:0] ALL_ONES      = 32'hffff_ffff;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	in_item_t   req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	out_item_t  rsp;

	queue_tracker tracker;

	// Idling percentages for the current phase, read by the sender task and
	// by the receiver process.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	// Fill level that the random stream is currently steering toward.
	int unsigned fill_goal = 0;
	int unsigned cycle_count = 0;

	fifo_queue_with_search #(
		.DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_fifo_queue_with_search failed");
			$finish;
		end
	end

	// Receiver side. The stall decision is registered at each edge, and the
	// response is taken at an edge where valid was high and stall was low,
	// using the values that were present just before that edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Presents one request item and returns at the edge where it is taken.
	// Must be called right after a rising edge. The sender may idle first, and
	// the item then stays put on the port until the block stops stalling.
	task automatic send_request(input in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		tracker.note_request(item);
	endtask

	task automatic issue(input req_type_t kind, input logic signed [VALUE_W-1:0] val);
		in_item_t item;
		item.req_type = kind;
		item.value = val;
		send_request(item);
	endtask

	// Holds the sender off until every outstanding response has come back.
	// The loop waits on a rising edge before it checks, so a following request starts on a fresh edge.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending_rsp.size() != 0);
	endtask

	// Builds one random request. The operation mix leans toward inserts while
	// the queue is below the current goal and toward removes above it, so the
	// stream keeps crossing the whole range from empty to full. Search values
	// are mostly taken from the entries held, sometimes with one bit flipped
	// so that near misses are exercised, and otherwise fully random.
	function automatic in_item_t random_request();
		in_item_t item;
		int unsigned roll;
		int unsigned pick;
		int unsigned held;
		held = tracker.held;
		if ($urandom_range(39) == 0) begin
			pick = $urandom_range(2);
			fill_goal = (pick == 0) ? 0 : (pick == 1) ? QUEUE_DEPTH :
				$urandom_range(QUEUE_DEPTH);
		end
		roll = $urandom_range(99);
		if (held < fill_goal)
			item.req_type = (roll < 55) ? REQ_INSERT : (roll < 70) ? REQ_REMOVE :
				(roll < 90) ? REQ_SEARCH : REQ_COUNT;
		else if (held > fill_goal)
			item.req_type = (roll < 15) ? REQ_INSERT : (roll < 70) ? REQ_REMOVE :
				(roll < 90) ? REQ_SEARCH : REQ_COUNT;
		else
			item.req_type = (roll < 30) ? REQ_INSERT : (roll < 60) ? REQ_REMOVE :
				(roll < 90) ? REQ_SEARCH : REQ_COUNT;

		item.value = $urandom;
		pick = $urandom_range(9);
		if (item.req_type == REQ_SEARCH && held > 0) begin
			if (pick < 5)
				item.value = tracker.held_value($urandom_range(held - 1));
			else if (pick < 7)
				item.value = tracker.held_value($urandom_range(held - 1)) ^
					(32'd1 << $urandom_range(VALUE_W - 1));
		end else if (item.req_type == REQ_INSERT) begin
			// Occasional extremes and duplicates of entries already held.
			if (pick == 0)
				item.value = ($urandom_range(1) == 0) ? MOST_NEGATIVE : MOST_POSITIVE;
			else if (pick == 1 && held > 0)
				item.value = tracker.held_value($urandom_range(held - 1));
		end
		return item;
	endfunction

	initial begin
		tracker = new;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening run, with no idling on either side. Both
		// underflow cases and a count come first on the empty queue.
		issue(REQ_REMOVE, 32'sd0);
		issue(REQ_SEARCH, ALL_ONES);
		issue(REQ_COUNT, 32'sd0);
		// Extremes of the value field, then searches that hit the last entry,
		// hit the first entry, and miss a stored value by a single bit.
		issue(REQ_INSERT, MOST_NEGATIVE);
		issue(REQ_INSERT, MOST_POSITIVE);
		issue(REQ_INSERT, 32'sd0);
		issue(REQ_INSERT, ALL_ONES);
		issue(REQ_SEARCH, ALL_ONES);
		issue(REQ_SEARCH, MOST_NEGATIVE);
		issue(REQ_SEARCH, 32'hffff_fffe);
		issue(REQ_REMOVE, 32'sd0);
		issue(REQ_COUNT, ALL_ONES);
		// Fill the queue to the top, so the indices wrap, and then push one
		// more insert that must be refused.
		while (tracker.held < QUEUE_DEPTH)
			issue(REQ_INSERT, $urandom);
		issue(REQ_INSERT, MOST_POSITIVE);
		issue(REQ_SEARCH, MOST_POSITIVE);
		wait_for_drain();

		// Random phases: no idling, sender idle, receiver stalling, then both.
		// The sender is held off until all responses are in between phases.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 57 : (phase == 3) ? 31 : 0;
			stall_pct     = (phase == 2) ? 57 : (phase == 3) ? 31 : 0;
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(random_request());
			wait_for_drain();
		end

		// Let any stray response surface before the final verdict.
		stall_pct = 0;
		repeat (12) @(posedge clk);
		if (tracker.pending_rsp.size() != 0) begin
			$error("%0d expected responses never arrived", tracker.pending_rsp.size());
			tracker.mismatches++;
		end

		$display("Ran %0d requests and checked %0d responses, peak fill %0d of %0d.",
			tracker.n_requests, tracker.n_checked, tracker.peak, QUEUE_DEPTH);
		$display("Refused inserts %0d, underflows %0d, searches found %0d, missed %0d.",
			tracker.n_full, tracker.n_empty, tracker.n_found, tracker.n_miss);
		if (tracker.mismatches == 0) begin
			$display("tb_fifo_queue_with_search passed");
		end else begin
			$display("tb_fifo_queue_with_search failed");
		end
		$finish;
	end

endmodule
